// ===== sv/tsls_pkg.sv =====
// Package for the split loss scan: widths, state types and the lane result type.
// Used by tsls_lane, tsls_merge and tree_split_loss_scan; depends on nothing.
package tsls_pkg;

  localparam int WEIGHT_W = 24;
  localparam int SUM_W    = 40;
  localparam int BASIS_W  = 16;
  localparam int OBSW_W   = 8;
  localparam int POS_W    = 16;
  localparam int LOSS_W   = 64;
  localparam int MAG_W    = 41;
  localparam int PROD_W   = 82;
  localparam int CNT_W    = 7;
  localparam int CFG_W    = 40;

  localparam int REG_MIN_LEAF = 0;
  localparam int REG_NODE_W   = 1;
  localparam int REG_SUM_BASE = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LANES,
    ST_MERGE,
    ST_OUT
  } scan_state_e;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_MUL,
    LN_DIV
  } lane_state_e;

  typedef struct packed {
    logic              done;
    logic [LOSS_W-1:0] term;
  } lane_res_t;

endpackage

// ===== sv/tsls_lane.sv =====
// One lane: squares a magnitude by shift and add, then divides it by a side weight.
// The quotient saturates at 2^63. Depends on tsls_pkg.
module tsls_lane import tsls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MAG_W-1:0]    mag_i,
  input  logic [WEIGHT_W-1:0] div_i,
  output lane_res_t           res_o
);

  lane_state_e         state_q, state_d;
  logic [CNT_W-1:0]    cnt_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   mcand_q;
  logic [MAG_W-1:0]    mplier_q;
  logic [WEIGHT_W-1:0] div_q;
  logic [WEIGHT_W-1:0] rem_q;
  logic                done_q;
  logic [WEIGHT_W:0]   rem_sh;
  logic                ge;

  localparam logic [CNT_W-1:0] MulLast = CNT_W'(MAG_W - 1);
  localparam logic [CNT_W-1:0] DivLast = CNT_W'(PROD_W - 1);

  assign rem_sh = {rem_q, prod_q[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LN_IDLE: if (start_i) state_d = LN_MUL;
      LN_MUL:  if (cnt_q == MulLast) state_d = LN_DIV;
      LN_DIV:  if (cnt_q == DivLast) state_d = LN_IDLE;
      default: state_d = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LN_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == LN_DIV) && (cnt_q == DivLast);
      if (state_q != state_d) cnt_q <= '0;
      else if (state_q != LN_IDLE) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      LN_IDLE: begin
        if (start_i) begin
          mcand_q  <= PROD_W'(mag_i);
          mplier_q <= mag_i;
          prod_q   <= '0;
          div_q    <= div_i;
        end
      end
      LN_MUL: begin
        if (mplier_q[0]) prod_q <= prod_q + mcand_q;
        mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[MAG_W-1:1]};
        rem_q    <= '0;
      end
      LN_DIV: begin
        if (ge) rem_q <= WEIGHT_W'(rem_sh - {1'b0, div_q});
        else    rem_q <= rem_sh[WEIGHT_W-1:0];
        prod_q <= {prod_q[PROD_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.term = (|prod_q[PROD_W-1:LOSS_W-1]) ? {1'b1, {(LOSS_W-1){1'b0}}}
                                                   : {1'b0, prod_q[LOSS_W-2:0]};

endmodule

// ===== sv/tsls_merge.sv =====
// Merging stage: adds the lane terms one per cycle and forms the negated loss.
// A total of 2^63 or more gives the most negative loss. Depends on tsls_pkg.
module tsls_merge import tsls_pkg::*; #(
  parameter int NUM_TERMS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [LOSS_W-1:0]        terms_i [NUM_TERMS],
  output logic                     done_o,
  output logic signed [LOSS_W-1:0] loss_o
);

  localparam int IDX_W = $clog2(NUM_TERMS);
  localparam int ACC_W = LOSS_W + IDX_W + 1;
  localparam logic [IDX_W-1:0] IdxLast = IDX_W'(NUM_TERMS - 1);

  logic             busy_q;
  logic             done_q;
  logic [IDX_W-1:0] idx_q;
  logic [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= busy_q && (idx_q == IdxLast);
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + IDX_W'(1);
        if (idx_q == IdxLast) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) acc_q <= '0;
    else if (busy_q) acc_q <= acc_q + ACC_W'(terms_i[idx_q]);
  end

  assign done_o = done_q;
  assign loss_o = (|acc_q[ACC_W-1:LOSS_W-1]) ? {1'b1, {(LOSS_W-1){1'b0}}}
                                             : LOSS_W'(0) - acc_q[LOSS_W-1:0];

endmodule

// ===== sv/tree_split_loss_scan.sv =====
// Top level of the split loss scan: running left sums, split checks and result register.
// Instantiates tsls_lane (two per basis) and tsls_merge; depends on tsls_pkg.
//
// Channel   Dir  Fields
// s_*       in   tdata: obs_weight, basis_0..; tuser: ties_next; tlast: final_obs
// m_*       out  tdata: best_loss, best_offset; tuser: split_found
// cfg_*     in   write enable, register index, write data
//
// An item that evaluates no split passes the accept and evaluation steps, a final item
// then also the result step; one that evaluates a split also passes through the
// serial squarer and divider in each lane and the serial adder in the merging stage.
// Reset clears all scan state and the result valid flag, but not the result data.
// A final item waits in the result step while an earlier result is still not taken.
module tree_split_loss_scan import tsls_pkg::*; #(
  parameter int NUM_BASIS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // obs_weight [7:0], then basis_b at [8+16b +: 16]
  input  logic [OBSW_W+BASIS_W*NUM_BASIS-1:0] s_tdata_i,
  // ties_next
  input  logic                             s_tuser_i,
  input  logic                             s_tlast_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // best_loss [63:0], best_offset [79:64]
  output logic [LOSS_W+POS_W-1:0]          m_tdata_o,
  // split_found
  output logic                             m_tuser_o,
  input  logic                             cfg_we_i,
  input  logic [$clog2(REG_SUM_BASE+NUM_BASIS)-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]                 cfg_data_i
);

  localparam int NUM_TERMS = 2 * NUM_BASIS;
  localparam int IDXW = $clog2(REG_SUM_BASE + NUM_BASIS);

  scan_state_e state_q, state_d;

  logic [WEIGHT_W-1:0]      min_q;
  logic [WEIGHT_W-1:0]      node_w_q;
  logic signed [SUM_W-1:0]  node_sum_q [NUM_BASIS];
  logic [WEIGHT_W-1:0]      lw_q;
  logic signed [SUM_W-1:0]  lsum_q [NUM_BASIS];
  logic signed [LOSS_W-1:0] best_q;
  logic [POS_W-1:0]         bpos_q;
  logic                     found_q;
  logic [POS_W-1:0]         pos_q;
  logic                     stop_q;
  logic                     tie_q;
  logic                     last_q;
  logic                     m_valid_q;
  logic [LOSS_W+POS_W-1:0]  m_data_q;
  logic                     m_user_q;

  logic                     accept;
  logic [WEIGHT_W:0]        lw_add;
  logic signed [WEIGHT_W:0] rw;
  logic                     left_ok;
  logic                     right_low;
  logic                     do_split;
  logic                     lanes_start;
  logic                     lanes_done;
  logic                     out_free;
  logic                     merge_done;
  logic signed [LOSS_W-1:0] merge_loss;
  logic [MAG_W-1:0]         lane_mag [NUM_TERMS];
  logic [WEIGHT_W-1:0]      lane_div [NUM_TERMS];
  lane_res_t                lane_res [NUM_TERMS];
  logic [LOSS_W-1:0]        terms [NUM_TERMS];
  logic [NUM_TERMS-1:0]     done_vec;

  assign accept    = s_tvalid_i && s_tready_o;
  assign lw_add    = {1'b0, lw_q} + (WEIGHT_W+1)'(s_tdata_i[OBSW_W-1:0]);
  assign rw        = $signed({1'b0, node_w_q}) - $signed({1'b0, lw_q});
  assign left_ok   = !stop_q && (lw_q >= min_q);
  assign right_low = rw < $signed({1'b0, min_q});
  assign do_split  = left_ok && !right_low && !tie_q && !last_q
                     && (lw_q != '0) && (rw != '0);
  assign out_free  = !m_valid_q || m_tready_i;
  assign lanes_done = &done_vec;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_EVAL;
      ST_EVAL: begin
        if (do_split) state_d = ST_LANES;
        else if (last_q) state_d = ST_OUT;
        else state_d = ST_IDLE;
      end
      ST_LANES: if (lanes_done) state_d = ST_MERGE;
      ST_MERGE: if (merge_done) state_d = ST_IDLE;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o  = 1'b0;
    lanes_start = 1'b0;
    unique case (state_q)
      ST_IDLE: s_tready_o  = 1'b1;
      ST_EVAL: lanes_start = do_split;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= WEIGHT_W'(1);
      node_w_q <= '0;
      for (int b = 0; b < NUM_BASIS; b++) node_sum_q[b] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == IDXW'(REG_MIN_LEAF)) min_q <= cfg_data_i[WEIGHT_W-1:0];
      if (cfg_idx_i == IDXW'(REG_NODE_W)) node_w_q <= cfg_data_i[WEIGHT_W-1:0];
      for (int b = 0; b < NUM_BASIS; b++) begin
        if (cfg_idx_i == IDXW'(REG_SUM_BASE + b)) node_sum_q[b] <= $signed(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q      <= '0;
      best_q    <= '0;
      bpos_q    <= '0;
      found_q   <= 1'b0;
      pos_q     <= '0;
      stop_q    <= 1'b0;
      tie_q     <= 1'b0;
      last_q    <= 1'b0;
      m_valid_q <= 1'b0;
      for (int b = 0; b < NUM_BASIS; b++) lsum_q[b] <= '0;
    end else begin
      if (state_q == ST_OUT && out_free) m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            tie_q  <= s_tuser_i;
            last_q <= s_tlast_i;
            if (!stop_q) begin
              lw_q <= lw_add[WEIGHT_W] ? {WEIGHT_W{1'b1}} : lw_add[WEIGHT_W-1:0];
              for (int b = 0; b < NUM_BASIS; b++) begin
                logic signed [OBSW_W+BASIS_W:0] p;
                logic signed [SUM_W:0]          s;
                p = $signed({1'b0, s_tdata_i[OBSW_W-1:0]})
                    * $signed(s_tdata_i[OBSW_W+BASIS_W*b +: BASIS_W]);
                s = (SUM_W+1)'(lsum_q[b]) + (SUM_W+1)'(p);
                if (s[SUM_W] != s[SUM_W-1])
                  lsum_q[b] <= s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
                else
                  lsum_q[b] <= s[SUM_W-1:0];
              end
            end
          end
        end
        ST_EVAL: begin
          if (left_ok && right_low) stop_q <= 1'b1;
          if (!do_split && !last_q) pos_q <= pos_q + POS_W'(1);
        end
        ST_MERGE: begin
          if (merge_done) begin
            if (merge_loss < best_q) begin
              best_q  <= merge_loss;
              bpos_q  <= pos_q;
              found_q <= 1'b1;
            end
            pos_q <= pos_q + POS_W'(1);
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_data_q  <= {bpos_q, best_q};
            m_user_q  <= found_q;
            lw_q      <= '0;
            best_q    <= '0;
            bpos_q    <= '0;
            found_q   <= 1'b0;
            pos_q     <= '0;
            stop_q    <= 1'b0;
            for (int b = 0; b < NUM_BASIS; b++) lsum_q[b] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < NUM_BASIS; b++) begin : g_basis
    logic signed [SUM_W:0] rsum;
    logic signed [SUM_W:0] lsx;
    assign lsx  = (SUM_W+1)'(lsum_q[b]);
    assign rsum = (SUM_W+1)'(node_sum_q[b]) - lsx;
    assign lane_mag[2*b]   = lsx[SUM_W] ? MAG_W'(-lsx) : MAG_W'(lsx);
    assign lane_mag[2*b+1] = rsum[SUM_W] ? MAG_W'(-rsum) : MAG_W'(rsum);
    assign lane_div[2*b]   = lw_q;
    assign lane_div[2*b+1] = rw[WEIGHT_W-1:0];
  end

  for (genvar t = 0; t < NUM_TERMS; t++) begin : g_lane
    tsls_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(lanes_start),
      .mag_i  (lane_mag[t]),
      .div_i  (lane_div[t]),
      .res_o  (lane_res[t])
    );
    assign terms[t]    = lane_res[t].term;
    assign done_vec[t] = lane_res[t].done;
  end

  tsls_merge #(.NUM_TERMS(NUM_TERMS)) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == ST_LANES && lanes_done),
    .terms_i(terms),
    .done_o (merge_done),
    .loss_o (merge_loss)
  );

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EVAL) else $error("accepted request not evaluated");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_valid_q && !m_tready_i) |=> state_q == ST_OUT)
    else $error("result overwrote a pending request");
  a_merge_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_done |-> state_q == ST_MERGE) else $error("merge finished outside merge step");
  a_lanes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lanes_done |-> state_q == ST_LANES) else $error("lanes finished outside lane step");

endmodule

// ===== bench/tree_split_loss_scan_test.sv =====
// Testbench for tree_split_loss_scan: streams sorted observation nodes and checks each
// best split result against a predictor kept in this file. Depends on tsls_pkg and the RTL.
module tree_split_loss_scan_test import tsls_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 4;
  localparam int IDXW = $clog2(REG_SUM_BASE + NB);
  localparam int SETTLE = 300;
  localparam int LIMIT = 3000000;
  localparam logic [63:0] MAG_SAT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [NB-1:0][15:0] basis;
    logic [7:0]          weight;
    logic                tie;
    logic                last;
  } obs_t;

  typedef struct {
    longint      loss;
    logic [15:0] offset;
    logic        found;
  } split_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_tvalid_i = 0;
  logic [OBSW_W+BASIS_W*NB-1:0] s_tdata_i = '0;
  logic s_tuser_i = 0;
  logic s_tlast_i = 0;
  logic m_tready_i = 0;
  logic cfg_we_i = 0;
  logic [$clog2(REG_SUM_BASE+NB)-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_tready_o, m_tvalid_o, m_tuser_o;
  logic [LOSS_W+POS_W-1:0] m_tdata_o;

  tree_split_loss_scan #(.NUM_BASIS(NB)) dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // Configuration and scan state of the predictor.
  logic [23:0] min_leaf, node_wt, left_wt;
  longint node_sum[NB], left_sum[NB];
  longint best_loss;
  logic [15:0] best_pos, obs_pos;
  logic found, stopped;

  split_t pending_splits[$];
  int errors = 0, results = 0, evaluated = 0, accepted = 0;
  int gap_pct = 0, stall_pct = 0, hold_cycles = 0, cycles = 0;
  obs_t node_q[$];

  function automatic logic [40:0] magnitude(longint v);
    return (v < 0) ? 41'(-v) : 41'(v);
  endfunction

  function automatic logic [63:0] square_quot(logic [40:0] m, logic [23:0] d);
    logic [81:0] sq, q;
    sq = {41'b0, m} * {41'b0, m};
    q = sq / {58'b0, d};
    return (q >= {18'b0, MAG_SAT}) ? MAG_SAT : q[63:0];
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    return (a >= MAG_SAT || b >= MAG_SAT - a) ? MAG_SAT : a + b;
  endfunction

  task automatic clear_scan();
    left_wt = '0;
    foreach (left_sum[k]) left_sum[k] = 0;
    best_loss = 0;
    best_pos = '0;
    found = 1'b0;
    obs_pos = '0;
    stopped = 1'b0;
  endtask

  task automatic predict_split(obs_t o);
    longint s, rw;
    logic [24:0] lw;
    logic [63:0] mag;
    longint loss;
    split_t r;
    if (!stopped) begin
      lw = {1'b0, left_wt} + 25'(o.weight);
      left_wt = lw[24] ? 24'hFFFFFF : lw[23:0];
      for (int k = 0; k < NB; k++) begin
        s = left_sum[k] + longint'(o.weight) * longint'($signed(o.basis[k]));
        if (s > 64'sd549755813887) s = 64'sd549755813887;
        if (s < -64'sd549755813888) s = -64'sd549755813888;
        left_sum[k] = s;
      end
      if (left_wt >= min_leaf) begin
        rw = longint'(node_wt) - longint'(left_wt);
        if (rw < longint'(min_leaf)) begin
          stopped = 1;
        end else if (!o.tie && !o.last && left_wt != 0 && rw != 0) begin
          mag = 0;
          for (int k = 0; k < NB; k++) begin
            mag = sat_sum(mag, square_quot(magnitude(left_sum[k]), left_wt));
            mag = sat_sum(mag, square_quot(magnitude(node_sum[k] - left_sum[k]), rw[23:0]));
          end
          loss = (mag >= MAG_SAT) ? 64'sh8000_0000_0000_0000 : -longint'(mag);
          evaluated++;
          if (loss < best_loss) begin
            best_loss = loss;
            best_pos = obs_pos;
            found = 1;
          end
        end
      end
    end
    if (o.last) begin
      r.loss = best_loss;
      r.offset = best_pos;
      r.found = found;
      pending_splits.push_back(r);
      clear_scan();
    end else begin
      obs_pos++;
    end
  endtask

  always @(posedge clk_i) begin
    obs_t o;
    split_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      if (s_tvalid_i && s_tready_o) begin
        o.weight = s_tdata_i[7:0];
        for (int k = 0; k < NB; k++) o.basis[k] = s_tdata_i[8+16*k +: 16];
        o.tie = s_tuser_i;
        o.last = s_tlast_i;
        accepted++;
        predict_split(o);
      end
      if (m_tvalid_o && m_tready_i) begin
        results++;
        if (pending_splits.size() == 0) begin
          $error("unexpected result loss=%0d", $signed(m_tdata_o[63:0]));
          errors++;
        end else begin
          e = pending_splits.pop_front();
          if ($signed(m_tdata_o[63:0]) != e.loss) begin
            $error("best_loss expected %0d actual %0d", e.loss, $signed(m_tdata_o[63:0]));
            errors++;
          end
          if (m_tdata_o[79:64] != e.offset) begin
            $error("best_offset expected %0d actual %0d", e.offset, m_tdata_o[79:64]);
            errors++;
          end
          if (m_tuser_o != e.found) begin
            $error("split_found expected %0d actual %0d", e.found, m_tuser_o);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_tready_i <= 0;
      hold_cycles--;
    end else begin
      m_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_obs(obs_t o);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid_i <= 0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1;
    s_tdata_i <= {o.basis, o.weight};
    s_tuser_i <= o.tie;
    s_tlast_i <= o.last;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_tvalid_i <= 0;
    while (pending_splits.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= IDXW'(idx);
    cfg_data_i <= val;
    if (idx == REG_MIN_LEAF) min_leaf = val[23:0];
    else if (idx == REG_NODE_W) node_wt = val[23:0];
    else node_sum[idx-REG_SUM_BASE] = longint'($signed(val));
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic obs_t make_obs(int w, int b, bit tie, bit last);
    obs_t o;
    o.weight = 8'(w);
    for (int k = 0; k < NB; k++) o.basis[k] = 16'((k % 2) ? -b : b);
    o.tie = tie;
    o.last = last;
    return o;
  endfunction

  // Configures the node from the queued items (sums mostly consistent) and streams it.
  task automatic run_node(int leaf, int sum_mode);
    longint tw;
    longint ts[NB];
    tw = 0;
    foreach (ts[k]) ts[k] = 0;
    foreach (node_q[i]) begin
      tw += node_q[i].weight;
      for (int k = 0; k < NB; k++)
        ts[k] += longint'(node_q[i].weight) * longint'($signed(node_q[i].basis[k]));
    end
    drain();
    write_reg(REG_MIN_LEAF, CFG_W'(leaf));
    write_reg(REG_NODE_W,
              CFG_W'((sum_mode == 1) ? longint'($urandom_range(16711680, 0)) : tw));
    for (int k = 0; k < NB; k++) begin
      case (sum_mode)
        1: write_reg(REG_SUM_BASE + k, CFG_W'({$urandom, $urandom}));
        2: write_reg(REG_SUM_BASE + k, (k % 2) ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF);
        default: write_reg(REG_SUM_BASE + k, CFG_W'(ts[k]));
      endcase
    end
    foreach (node_q[i]) send_obs(node_q[i]);
    node_q.delete();
  endtask

  function automatic obs_t rand_obs(bit last);
    obs_t o;
    o.weight = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 0));
    for (int k = 0; k < NB; k++) o.basis[k] = 16'($urandom);
    o.tie = ($urandom_range(3) == 0);
    o.last = last;
    return o;
  endfunction

  task automatic test_directed();
    node_q.push_back(make_obs(255, 32767, 0, 1));
    run_node(1, 0);
    node_q.push_back(make_obs(255, -32768, 0, 0));
    node_q.push_back(make_obs(0, 0, 0, 1));
    run_node(1, 1);
    node_q.push_back(make_obs(0, 100, 0, 0));
    node_q.push_back(make_obs(3, -200, 0, 1));
    run_node(0, 0);
    node_q.push_back(make_obs(5, 4000, 1, 0));
    node_q.push_back(make_obs(5, 9000, 0, 0));
    node_q.push_back(make_obs(0, 7, 0, 0));
    node_q.push_back(make_obs(9, -16000, 0, 0));
    node_q.push_back(make_obs(1, -5, 0, 1));
    run_node(1, 0);
    node_q.push_back(make_obs(200, 32767, 0, 0));
    node_q.push_back(make_obs(200, -32768, 0, 0));
    node_q.push_back(make_obs(200, 1, 0, 1));
    run_node(16711680, 0);
    node_q.push_back(make_obs(1, 32767, 0, 0));
    node_q.push_back(make_obs(1, -32768, 0, 0));
    node_q.push_back(make_obs(1, 32767, 0, 1));
    run_node(1, 2);
    node_q.push_back(make_obs(100, 1234, 0, 0));
    node_q.push_back(make_obs(100, -4321, 0, 0));
    node_q.push_back(make_obs(20, 77, 0, 0));
    node_q.push_back(make_obs(30, 55, 0, 1));
    run_node(60, 0);
  endtask

  task automatic test_random(int gap, int stall, int items);
    int sent, len, pick, leaf;
    gap_pct = gap;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) node_q.push_back(rand_obs(i == len - 1));
      pick = $urandom_range(9);
      leaf = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(16711680, 0)
                         : $urandom_range(200, 1);
      run_node(leaf, (pick == 2) ? 1 : (pick == 3) ? 2 : 0);
      sent += len;
    end
  endtask

  // The receiver holds off while several nodes stream in with one setting.
  task automatic test_backpressure();
    int len;
    gap_pct = 0;
    stall_pct = 0;
    drain();
    write_reg(REG_MIN_LEAF, CFG_W'(1));
    write_reg(REG_NODE_W, CFG_W'(600));
    for (int k = 0; k < NB; k++) write_reg(REG_SUM_BASE + k, CFG_W'({$urandom, $urandom}));
    hold_cycles = 4000;
    for (int n = 0; n < 8; n++) begin
      len = $urandom_range(5, 2);
      for (int i = 0; i < len; i++) send_obs(rand_obs(i == len - 1));
    end
  endtask

  initial begin
    min_leaf = 24'd1;
    node_wt = '0;
    foreach (node_sum[k]) node_sum[k] = 0;
    clear_scan();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    test_directed();
    test_random(23, 84, 350);
    test_random(84, 23, 350);
    test_random(0, 0, 350);
    test_backpressure();
    drain();
    $display("Accepted %0d observations, evaluated %0d splits, checked %0d results.",
             accepted, evaluated, results);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
